// ===== design/smd_pkg.sv =====
// Shared types and constants for the scope min/max decimator.
// No dependencies; used by the channel interfaces and the top level.
package smd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCALED_W = 18;
   localparam int SLOT_W   = 9;
   localparam int GAIN_W   = 16;
   localparam int SHIFT_W  = 16;
   localparam int TSCALE_W = 6;
   localparam int SPAN_W   = 10;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = 32;
   localparam int FRAC_W   = 14;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;

   localparam csr_idx_type CSR_GAIN        = 2'd0;
   localparam csr_idx_type CSR_LEVEL_SHIFT = 2'd1;
   localparam csr_idx_type CSR_TIME_SCALE  = 2'd2;

   localparam logic [GAIN_W-1:0]   GAIN_MAX     = 16'd32768;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;
   localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 16'd0;
   localparam logic [TSCALE_W-1:0] TSCALE_RESET = 6'd32;

   localparam scaled_type SCALED_MAX = 18'sh1FFFF;
   localparam scaled_type SCALED_MIN = 18'sh20000;

endpackage

// ===== design/smd_ifs.sv =====
// Valid/ready channel interfaces for the scope min/max decimator.
// Depends on smd_pkg for the payload types.
interface smd_req_if;
   logic               valid;
   logic               ready;
   smd_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface smd_rsp_if;
   logic                valid;
   logic                ready;
   smd_pkg::scaled_type scaled_sample;
   logic                capture_valid;
   smd_pkg::scaled_type capture_min;
   smd_pkg::scaled_type capture_max;
   smd_pkg::slot_type   capture_slot;

   modport source (output valid, output scaled_sample, output capture_valid,
                   output capture_min, output capture_max, output capture_slot,
                   input ready);
   modport sink   (input valid, input scaled_sample, input capture_valid,
                   input capture_min, input capture_max, input capture_slot,
                   output ready);
endinterface

// ===== design/scope_minmax_decimator.sv =====
// Scope min/max decimator: scales each sample by gain and offset, tracks the
// span minimum and maximum and emits a pair with its ring slot per span.
// Depends on smd_pkg and the channel interfaces in smd_ifs.sv.
//
// Usage:
//   req_chan carries one signed Q15 sample per request; rsp_chan returns one
//   result per request: the scaled sample and, when a span closes on that
//   sample, the min/max pair with its ring slot (all capture fields zero
//   otherwise). csr_* writes gain, level shift and time scale; write them
//   only while no request is in flight.
//   The multiply is registered at accept; the offset add, min/max compare
//   and span counter settle in the second stage into the result register.
//   Throughput is one request per cycle while rsp_chan does not stall, set
//   by the single multiplier stage and the tracker update.
//   When rsp_chan stalls, the two stages fill and req_chan.ready drops;
//   nothing is lost or repeated.
//   Reset (synchronous) empties the pipeline, restores the register
//   defaults (unity gain, zero shift, time scale 32) and restarts the span
//   tracker at slot zero.
module scope_minmax_decimator #(
   parameter int FRAME_SIZE      = 32,
   parameter int RING_DEPTH      = 512,
   parameter int SLOW_RING_DEPTH = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   smd_req_if.sink                      req_chan,
   smd_rsp_if.source                    rsp_chan,
   input  logic                         csr_write,
   input  smd_pkg::csr_idx_type         csr_index,
   input  logic [smd_pkg::CSR_W-1:0]    csr_data
);

   localparam int DEPTH_MAX = (RING_DEPTH > SLOW_RING_DEPTH) ? RING_DEPTH : SLOW_RING_DEPTH;
   localparam int WP_W      = $clog2(DEPTH_MAX);
   localparam int RSLOT_W   = $clog2(RING_DEPTH);

   logic [smd_pkg::GAIN_W-1:0]   gain_ff;
   logic signed [smd_pkg::SHIFT_W-1:0] shift_ff;
   logic [smd_pkg::TSCALE_W-1:0] tscale_ff;

   logic                         s1_valid_ff;
   logic signed [smd_pkg::PROD_W-1:0] prod_ff;
   logic signed [smd_pkg::PROD_W-1:0] prod_in;

   logic                         rsp_valid_ff;
   smd_pkg::scaled_type          scaled_ff, scaled_in;
   logic                         cap_valid_ff, cap_valid_in;
   smd_pkg::scaled_type          cap_min_ff, cap_min_in;
   smd_pkg::scaled_type          cap_max_ff, cap_max_in;
   logic [RSLOT_W-1:0]           cap_slot_ff, cap_slot_in;

   smd_pkg::scaled_type          span_min_ff, span_min_in;
   smd_pkg::scaled_type          span_max_ff, span_max_in;
   logic [smd_pkg::SPAN_W-1:0]   span_count_ff, span_count_in;
   logic [WP_W-1:0]              wpos_ff, wpos_in;
   logic [RSLOT_W-1:0]           rslot_ff, rslot_in;

   logic                         advance;
   logic                         slow;
   logic [smd_pkg::SPAN_W-1:0]   span;
   logic [smd_pkg::SPAN_W-1:0]   tscale_ext;
   logic [smd_pkg::SPAN_W:0]     count_inc;
   logic                         capture;
   smd_pkg::scaled_type          y;
   smd_pkg::scaled_type          new_min, new_max;
   logic [WP_W:0]                wpos_inc;
   logic [WP_W:0]                wrap_limit;
   logic [RSLOT_W:0]             rslot_inc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= smd_pkg::GAIN_RESET;
         shift_ff  <= smd_pkg::SHIFT_RESET;
         tscale_ff <= smd_pkg::TSCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            smd_pkg::CSR_GAIN: begin
               gain_ff <= (csr_data > smd_pkg::GAIN_MAX) ? smd_pkg::GAIN_MAX : csr_data;
            end
            smd_pkg::CSR_LEVEL_SHIFT: begin
               shift_ff <= csr_data;
            end
            smd_pkg::CSR_TIME_SCALE: begin
               tscale_ff <= csr_data[smd_pkg::TSCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;

   // stage 1: multiply at accept
   assign prod_in = smd_pkg::PROD_W'(req_chan.sample)
                    * smd_pkg::PROD_W'($signed({1'b0, gain_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: offset, min/max track, span counter, ring slot
   always_comb begin
      y = prod_ff[smd_pkg::FRAC_W+smd_pkg::SCALED_W-1:smd_pkg::FRAC_W]
          + smd_pkg::scaled_type'(shift_ff);

      tscale_ext = smd_pkg::SPAN_W'(tscale_ff);
      slow       = tscale_ext > smd_pkg::SPAN_W'(FRAME_SIZE);
      span       = slow ? smd_pkg::SPAN_W'((tscale_ext - smd_pkg::SPAN_W'(FRAME_SIZE))
                                           * smd_pkg::SPAN_W'(FRAME_SIZE))
                        : tscale_ext;

      new_min = (y < span_min_ff) ? y : span_min_ff;
      new_max = (y > span_max_ff) ? y : span_max_ff;

      count_inc = {1'b0, span_count_ff} + 1'b1;
      capture   = count_inc > {1'b0, span};

      wrap_limit = slow ? (WP_W+1)'(SLOW_RING_DEPTH) : (WP_W+1)'(RING_DEPTH);
      wpos_inc   = {1'b0, wpos_ff} + 1'b1;
      rslot_inc  = {1'b0, rslot_ff} + 1'b1;

      scaled_in    = y;
      cap_valid_in = capture;
      cap_min_in   = capture ? new_min : '0;
      cap_max_in   = capture ? new_max : '0;
      cap_slot_in  = capture ? rslot_ff : '0;

      span_min_in   = new_min;
      span_max_in   = new_max;
      span_count_in = count_inc[smd_pkg::SPAN_W-1:0];
      wpos_in       = wpos_ff;
      rslot_in      = rslot_ff;
      if (capture) begin
         span_min_in   = smd_pkg::SCALED_MAX;
         span_max_in   = smd_pkg::SCALED_MIN;
         span_count_in = '0;
         if (wpos_inc >= wrap_limit) begin
            wpos_in  = '0;
            rslot_in = '0;
         end else begin
            wpos_in  = wpos_inc[WP_W-1:0];
            rslot_in = (rslot_inc == (RSLOT_W+1)'(RING_DEPTH)) ? '0 : rslot_inc[RSLOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         span_min_ff   <= smd_pkg::SCALED_MAX;
         span_max_ff   <= smd_pkg::SCALED_MIN;
         span_count_ff <= '0;
         wpos_ff       <= '0;
         rslot_ff      <= '0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            span_min_ff   <= span_min_in;
            span_max_ff   <= span_max_in;
            span_count_ff <= span_count_in;
            wpos_ff       <= wpos_in;
            rslot_ff      <= rslot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         scaled_ff    <= scaled_in;
         cap_valid_ff <= cap_valid_in;
         cap_min_ff   <= cap_min_in;
         cap_max_ff   <= cap_max_in;
         cap_slot_ff  <= cap_slot_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.scaled_sample = scaled_ff;
   assign rsp_chan.capture_valid = cap_valid_ff;
   assign rsp_chan.capture_min   = cap_min_ff;
   assign rsp_chan.capture_max   = cap_max_ff;
   assign rsp_chan.capture_slot  = smd_pkg::SLOT_W'(cap_slot_ff);

`ifndef NO_ASSERTIONS
   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cap_valid_ff |-> cap_min_ff <= cap_max_ff)
      else $error("captured minimum above captured maximum");

   a_no_capture_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !cap_valid_ff |-> cap_min_ff == '0 && cap_max_ff == '0
                                        && cap_slot_ff == '0)
      else $error("capture fields not cleared without a capture");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rslot_ff < (RSLOT_W+1)'(RING_DEPTH))
      else $error("ring slot out of range");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_chan.ready)
      else $error("request stalled while pipeline has room");

   a_tracker_restart: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && capture |=> span_count_ff == '0
                                            && span_min_ff == smd_pkg::SCALED_MAX)
      else $error("span tracker not restarted after capture");
`endif

endmodule

// ===== tb/smd_checker.sv =====
// Checker for the scope min/max decimator: tracks register writes, predicts each
// response from the accepted requests and compares it field by field.
// Depends on smd_pkg and the channel interfaces in smd_ifs.sv.
module smd_checker #(
   parameter int FRAME_SIZE      = 32,
   parameter int RING_DEPTH      = 512,
   parameter int SLOW_RING_DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   smd_req_if                        req_mon,
   smd_rsp_if                        rsp_mon,
   input  logic                      csr_write,
   input  smd_pkg::csr_idx_type      csr_index,
   input  logic [smd_pkg::CSR_W-1:0] csr_data,
   output int                        fail_count,
   output int                        outstanding,
   output int                        pairs_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      smd_pkg::scaled_type scaled;
      logic                hit;
      smd_pkg::scaled_type lo;
      smd_pkg::scaled_type hi;
      smd_pkg::slot_type   slot;
   } scope_point_type;

   logic [smd_pkg::GAIN_W-1:0]         gain_q;
   logic signed [smd_pkg::SHIFT_W-1:0] shift_q;
   logic [smd_pkg::TSCALE_W-1:0]       tscale_q;
   smd_pkg::scaled_type                lo_q;
   smd_pkg::scaled_type                hi_q;
   int                                 count_q;
   int                                 wpos_q;
   scope_point_type                    expected_q[$];
   int                                 errors = 0;
   int                                 captured = 0;
   int                                 responses = 0;

   function automatic scope_point_type track_sample(smd_pkg::sample_type s);
      scope_point_type p;
      int              prod;
      int              y;
      int              span;
      int              wrap_at;
      logic            slow;
      prod    = int'(s) * int'(gain_q);
      y       = (prod >>> smd_pkg::FRAC_W) + int'(shift_q);
      slow    = tscale_q > FRAME_SIZE;
      span    = slow ? (int'(tscale_q) - FRAME_SIZE) * FRAME_SIZE : int'(tscale_q);
      wrap_at = slow ? SLOW_RING_DEPTH : RING_DEPTH;
      if (y < lo_q) lo_q = smd_pkg::scaled_type'(y);
      if (y > hi_q) hi_q = smd_pkg::scaled_type'(y);
      p        = '0;
      p.scaled = smd_pkg::scaled_type'(y);
      count_q++;
      if (count_q > span) begin
         p.hit  = 1'b1;
         p.lo   = lo_q;
         p.hi   = hi_q;
         p.slot = smd_pkg::slot_type'(wpos_q % RING_DEPTH);
         wpos_q++;
         if (wpos_q >= wrap_at) wpos_q = 0;
         count_q = 0;
         lo_q    = smd_pkg::SCALED_MAX;
         hi_q    = smd_pkg::SCALED_MIN;
      end
      return p;
   endfunction

   task automatic flag(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic signed [31:0] got,
                              logic signed [31:0] want);
      if (got !== want)
         flag($sformatf("response %0d: %s got %0d expected %0d", responses, name, got,
                        want));
   endtask

   always @(posedge clock) begin
      scope_point_type want;
      if (reset) begin
         gain_q   = smd_pkg::GAIN_RESET;
         shift_q  = smd_pkg::SHIFT_RESET;
         tscale_q = smd_pkg::TSCALE_RESET;
         lo_q     = smd_pkg::SCALED_MAX;
         hi_q     = smd_pkg::SCALED_MIN;
         count_q  = 0;
         wpos_q   = 0;
         expected_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               smd_pkg::CSR_GAIN: begin
                  gain_q = (csr_data > smd_pkg::GAIN_MAX) ? smd_pkg::GAIN_MAX : csr_data;
               end
               smd_pkg::CSR_LEVEL_SHIFT: shift_q = csr_data;
               smd_pkg::CSR_TIME_SCALE:  tscale_q = csr_data[smd_pkg::TSCALE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rsp_mon.capture_valid === 1'b1) captured++;
            if (expected_q.size() == 0) begin
               flag($sformatf("response %0d arrived with no request outstanding",
                              responses));
            end else begin
               want = expected_q.pop_front();
               check_field("scaled_sample", rsp_mon.scaled_sample, want.scaled);
               check_field("capture_valid", rsp_mon.capture_valid, want.hit);
               check_field("capture_min", rsp_mon.capture_min, want.lo);
               check_field("capture_max", rsp_mon.capture_max, want.hi);
               check_field("capture_slot", rsp_mon.capture_slot, want.slot);
            end
            responses++;
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(track_sample(req_mon.sample));
      end
      fail_count  <= errors;
      outstanding <= expected_q.size();
      pairs_seen  <= captured;
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the scope min/max decimator testbench: clock, reset, register writes,
// paced sample requests and response stalls, and the final verdict.
// Depends on smd_pkg, smd_ifs.sv, the block and tb/smd_checker.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_SIZE      = 32;
   localparam int RING_DEPTH      = 512;
   localparam int SLOW_RING_DEPTH = 128;
   localparam smd_pkg::csr_idx_type CSR_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      csr_write;
   smd_pkg::csr_idx_type      csr_index;
   logic [smd_pkg::CSR_W-1:0] csr_data;
   int                        send_idle;
   int                        recv_stall;
   int                        sent;
   int                        csr_writes;
   int                        fail_count;
   int                        outstanding;
   int                        pairs_seen;

   smd_req_if req_chan ();
   smd_rsp_if rsp_chan ();

   scope_minmax_decimator #(
      .FRAME_SIZE      (FRAME_SIZE),
      .RING_DEPTH      (RING_DEPTH),
      .SLOW_RING_DEPTH (SLOW_RING_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   smd_checker #(
      .FRAME_SIZE      (FRAME_SIZE),
      .RING_DEPTH      (RING_DEPTH),
      .SLOW_RING_DEPTH (SLOW_RING_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .pairs_seen  (pairs_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** scope_minmax_decimator: FAILED **");
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_sample(smd_pkg::sample_type s);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic write_csr(smd_pkg::csr_idx_type idx, logic [smd_pkg::CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_writes++;
   endtask

   // drop valid and wait until every request has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic smd_pkg::sample_type pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return smd_pkg::sample_type'(int'($urandom_range(32)) - 16);
         default: return smd_pkg::sample_type'($urandom);
      endcase
   endfunction

   task automatic program_random(bit zero_span);
      logic [smd_pkg::CSR_W-1:0]    gain_val;
      logic [smd_pkg::CSR_W-1:0]    shift_val;
      logic [smd_pkg::TSCALE_W-1:0] ts;
      case ($urandom_range(5))
         0:       gain_val = '0;
         1:       gain_val = smd_pkg::GAIN_RESET;
         2:       gain_val = smd_pkg::GAIN_MAX;
         3:       gain_val = 16'($urandom_range(32769, 65535));
         default: gain_val = 16'($urandom);
      endcase
      case ($urandom_range(3))
         0:       shift_val = 16'h7FFF;
         1:       shift_val = 16'h8000;
         default: shift_val = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0, 1, 2: ts = '0;
         3, 4:    ts = 6'($urandom_range(1, 4));
         5:       ts = 6'($urandom_range(5, 32));
         6, 7:    ts = 6'($urandom_range(33, 35));
         8:       ts = 6'd63;
         default: ts = 6'($urandom_range(36, 62));
      endcase
      if (zero_span) ts = '0;
      write_csr(smd_pkg::CSR_GAIN, gain_val);
      write_csr(smd_pkg::CSR_LEVEL_SHIFT, shift_val);
      // upper data bits carry junk now and then
      write_csr(smd_pkg::CSR_TIME_SCALE,
                16'(ts) | ($urandom_range(1) ? 16'($urandom) & 16'hFFC0 : 16'h0));
      if ($urandom_range(7) == 0) write_csr(CSR_UNUSED, 16'($urandom));
      csr_write <= 1'b0;
   endtask

   initial begin
      int idle_pct[4];
      int stall_pct[4];
      int budget[4];
      int done;
      int n;
      bit first;
      idle_pct   = '{0, 62, 0, 20};
      stall_pct  = '{0, 0, 62, 20};
      budget     = '{640, 200, 200, 200};
      sent       = 0;
      csr_writes = 0;
      send_idle  = 0;
      recv_stall = 0;
      reset           <= 1'b1;
      csr_write       <= 1'b0;
      csr_index       <= smd_pkg::CSR_GAIN;
      csr_data        <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: long span, no capture
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      settle();
      // full gain, top shift, pair on every sample
      write_csr(smd_pkg::CSR_GAIN, smd_pkg::GAIN_MAX);
      write_csr(smd_pkg::CSR_LEVEL_SHIFT, 16'h7FFF);
      write_csr(smd_pkg::CSR_TIME_SCALE, 16'd0);
      csr_write <= 1'b0;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      settle();
      // gain above range saturates, bottom shift
      write_csr(smd_pkg::CSR_GAIN, 16'hFFFF);
      write_csr(smd_pkg::CSR_LEVEL_SHIFT, 16'h8000);
      csr_write <= 1'b0;
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sd1);
      settle();
      // truncation of a just-below-unity gain; write to the unused index
      write_csr(smd_pkg::CSR_GAIN, 16'd16383);
      write_csr(CSR_UNUSED, 16'h1234);
      write_csr(smd_pkg::CSR_LEVEL_SHIFT, 16'd0);
      csr_write <= 1'b0;
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh8000);
      settle();
      // zero gain in the longest slow span
      write_csr(smd_pkg::CSR_GAIN, 16'd0);
      write_csr(smd_pkg::CSR_TIME_SCALE, 16'd63);
      csr_write <= 1'b0;
      send_sample(16'sd12345);
      send_sample(-16'sd7);
      send_sample(16'sd4);
      settle();
      // shrink the span below the running count
      write_csr(smd_pkg::CSR_GAIN, smd_pkg::GAIN_RESET);
      write_csr(smd_pkg::CSR_TIME_SCALE, 16'd1);
      csr_write <= 1'b0;
      send_sample(16'sd5);
      send_sample(16'sd6);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = idle_pct[ph];
         recv_stall = stall_pct[ph];
         done  = 0;
         first = (ph == 0);
         while (done < budget[ph]) begin
            settle();
            program_random(first);
            n = first ? 520 : int'($urandom_range(30, 90));
            first = 1'b0;
            if (n > budget[ph] - done) n = budget[ph] - done;
            repeat (n) send_sample(pick_sample());
            done += n;
         end
      end
      settle();

      $display("Run covered %0d samples over four pacing phases and %0d register writes;",
               sent, csr_writes);
      $display("%0d min/max pairs were captured and checked.", pairs_seen);
      if (fail_count == 0) begin
         $display("** scope_minmax_decimator: PASSED **");
      end else begin
         $display("** scope_minmax_decimator: FAILED **");
      end
      $finish;
   end

endmodule
